// File: rtl/bit_field_copy_aligner_assert.svh
// assertion macros for the bit field copy aligner checker
// used by bfca_checker.sv only, no other dependencies
`ifndef BIT_FIELD_COPY_ALIGNER_ASSERT_SVH
`define BIT_FIELD_COPY_ALIGNER_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define BFCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define BFCA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bfca_pkg.sv
// shared types, constants and bit helpers for the bit field copy aligner
// no dependencies
package bfca_pkg;

    localparam int HALF_W          = 16;
    localparam int OFS_W           = 4;
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int CFG_IDX_W       = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_SRC_OFS   = t_cfg_idx'(0);
    localparam t_cfg_idx REG_DST_OFS   = t_cfg_idx'(1);
    localparam t_cfg_idx REG_BIT_COUNT = t_cfg_idx'(2);
    localparam t_cfg_idx REG_MSB_FIRST = t_cfg_idx'(3);

    typedef struct packed {
        logic              valid;
        logic [HALF_W-1:0] half;
    } t_stage;

    typedef struct packed {
        logic [HALF_W-1:0] dst_half;
        logic [HALF_W-1:0] write_mask;
        logic              last_out;
    } t_dst_item;

    typedef struct packed {
        logic      emit0;
        logic      emit1;
        t_dst_item res0;
        t_dst_item res1;
    } t_res_pair;

    // reverse bit order within each byte
    function automatic logic [HALF_W-1:0] swap_byte_bits(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[7 - i]  = v[i];
            r[15 - i] = v[8 + i];
        end
        return r;
    endfunction

    // n ones from bit 0, n in 0..16
    function automatic logic [HALF_W-1:0] low_ones(input logic [4:0] n);
        logic [HALF_W-1:0] r;
        r = n[4] ? {HALF_W{1'b1}} : ~({HALF_W{1'b1}} << n[3:0]);
        return r;
    endfunction

endpackage

// File: rtl/bfca_if.sv
// source and destination stream interfaces of the bit field copy aligner
// depends on bfca_pkg
interface bfca_src_if;
    logic                       valid;
    logic                       ready;
    logic [bfca_pkg::HALF_W-1:0] src_half;

    modport source (output valid, output src_half, input ready);
    modport sink   (input valid, input src_half, output ready);
endinterface

interface bfca_dst_if;
    logic                       valid;
    logic                       ready;
    logic [bfca_pkg::HALF_W-1:0] dst_half;
    logic [bfca_pkg::HALF_W-1:0] write_mask;
    logic                       last_out;

    modport source (output valid, output dst_half, output write_mask, output last_out,
                    input ready);
    modport sink   (input valid, input dst_half, input write_mask, input last_out,
                    output ready);
endinterface

// File: rtl/bit_field_copy_aligner.sv
// top level of the bit field copy aligner
// depends on bfca_pkg, bfca_if, bfca_in_stage, bfca_core and bfca_out_stage
//
// Streams source half-words and copies a run of bit_count bits, starting at
// src_bit_offset in the first source half-word, to destination half-words
// starting at dst_bit_offset, each result carrying a write mask so the caller
// keeps bits outside the run. One source transaction is taken per clock while
// i_src.ready is high; its results pass through the input register, then the
// shift and mask logic into a two-slot result register. Every source transaction
// gives at most one result except the one that completes the copy, which may
// give two in turn; i_src.ready drops only while the result register holds
// a result that o_dst has not taken. Register writes re-arm the block for a new
// copy and are to be made only when no transaction is in flight; the next source
// transaction starts the copy. Extra source transactions after the last result
// are taken and dropped.
module bit_field_copy_aligner #(
    parameter int COUNT_WIDTH = bfca_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  bfca_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [COUNT_WIDTH-1:0] i_cfg_data,
    bfca_src_if.sink               i_src,
    bfca_dst_if.source             o_dst
);

    bfca_pkg::t_stage    stage;
    bfca_pkg::t_res_pair res;
    logic                can_load;
    logic                adv;

    assign adv = stage.valid && can_load;

    bfca_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_adv   (adv),
        .o_stage (stage)
    );

    bfca_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stage    (stage),
        .i_adv      (adv),
        .o_res      (res)
    );

    bfca_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_res      (res),
        .o_can_load (can_load),
        .o_dst      (o_dst)
    );

endmodule

// File: rtl/bfca_in_stage.sv
// input register of the bit field copy aligner
// depends on bfca_pkg and bfca_src_if
module bfca_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bfca_src_if.sink         i_src,
    input  logic             i_adv,
    output bfca_pkg::t_stage o_stage
);

    logic                        r_valid;
    logic                        n_valid;
    logic [bfca_pkg::HALF_W-1:0] r_half;
    logic                        accept;

    assign i_src.ready = !r_valid || i_adv;
    assign accept      = i_src.valid && i_src.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_half <= i_src.src_half;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.half  = r_half;

endmodule

// File: rtl/bfca_core.sv
// alignment state, configuration registers and per-transaction shift and mask logic
// depends on bfca_pkg
module bfca_core #(
    parameter int COUNT_WIDTH = bfca_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  bfca_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [COUNT_WIDTH-1:0] i_cfg_data,
    input  bfca_pkg::t_stage     i_stage,
    input  logic                 i_adv,
    output bfca_pkg::t_res_pair  o_res
);

    localparam int HW = bfca_pkg::HALF_W;
    localparam int OW = bfca_pkg::OFS_W;

    logic [OW-1:0]          r_src_ofs;
    logic [OW-1:0]          r_dst_ofs;
    logic [COUNT_WIDTH-1:0] r_bit_count;
    logic                   r_msb_first;

    logic [HW-1:0]          r_pend;
    logic [HW-1:0]          n_pend;
    logic [OW-1:0]          r_pcnt;
    logic [OW-1:0]          n_pcnt;
    logic [COUNT_WIDTH-1:0] r_bits_left;
    logic [COUNT_WIDTH-1:0] n_bits_left;
    logic                   r_first;
    logic                   n_first;
    logic                   r_fresh;
    logic                   n_fresh;

    logic                   cfg_hit;
    logic [HW-1:0]          lin;
    logic [COUNT_WIDTH-1:0] bl;
    logic [COUNT_WIDTH-1:0] bl1;
    logic [OW-1:0]          lo;
    logic [4:0]             cur;
    logic [4:0]             avail;
    logic [4:0]             run_max;
    logic [4:0]             run0;
    logic [4:0]             c1;
    logic [2*HW-1:0]        p;
    logic [HW-1:0]          p1;
    logic [HW-1:0]          mask0;
    logic [HW-1:0]          mask1;
    logic [HW-1:0]          data0;
    logic [HW-1:0]          data1;
    logic                   active;
    logic                   emit0;
    logic                   emit1;
    logic                   last0;

    assign cfg_hit = i_cfg_we && ((i_cfg_idx == bfca_pkg::REG_SRC_OFS)
                               || (i_cfg_idx == bfca_pkg::REG_DST_OFS)
                               || (i_cfg_idx == bfca_pkg::REG_BIT_COUNT)
                               || (i_cfg_idx == bfca_pkg::REG_MSB_FIRST));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_ofs   <= '0;
            r_dst_ofs   <= '0;
            r_bit_count <= '0;
            r_msb_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfca_pkg::REG_SRC_OFS:   r_src_ofs   <= i_cfg_data[OW-1:0];
                bfca_pkg::REG_DST_OFS:   r_dst_ofs   <= i_cfg_data[OW-1:0];
                bfca_pkg::REG_BIT_COUNT: r_bit_count <= i_cfg_data;
                bfca_pkg::REG_MSB_FIRST: r_msb_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // shift, merge and mask for one transaction
    always_comb begin
        lin    = r_msb_first ? bfca_pkg::swap_byte_bits(i_stage.half) : i_stage.half;
        bl     = r_first ? r_bit_count : r_bits_left;
        active = (bl != '0);
        lo     = (r_first || r_fresh) ? r_dst_ofs : '0;
        if (r_first) begin
            p   = ({{HW{1'b0}}, lin} >> r_src_ofs) << r_dst_ofs;
            cur = {1'b0, r_dst_ofs} + 5'd16 - {1'b0, r_src_ofs};
        end else begin
            p   = {{HW{1'b0}}, r_pend} | ({{HW{1'b0}}, lin} << r_pcnt);
            cur = {1'b0, r_pcnt} + 5'd16;
        end
        avail   = cur - {1'b0, lo};
        emit0   = active && (cur[4] || (COUNT_WIDTH'(avail) >= bl));
        run_max = 5'd16 - {1'b0, lo};
        run0    = (bl < COUNT_WIDTH'(run_max)) ? bl[4:0] : run_max;
        mask0   = bfca_pkg::low_ones(run0) << lo;
        data0   = p[HW-1:0] & mask0;
        bl1     = bl - COUNT_WIDTH'(run0);
        last0   = (bl1 == '0);
        p1      = cur[4] ? p[2*HW-1:HW] : '0;
        c1      = cur[4] ? {1'b0, cur[3:0]} : 5'd0;
        emit1   = emit0 && !last0 && (COUNT_WIDTH'(c1) >= bl1);
        mask1   = bfca_pkg::low_ones(bl1[4:0]);
        data1   = p1 & mask1;
    end

    always_comb begin
        o_res.emit0               = emit0;
        o_res.emit1               = emit1;
        o_res.res0.dst_half       = r_msb_first ? bfca_pkg::swap_byte_bits(data0) : data0;
        o_res.res0.write_mask     = r_msb_first ? bfca_pkg::swap_byte_bits(mask0) : mask0;
        o_res.res0.last_out       = last0;
        o_res.res1.dst_half       = r_msb_first ? bfca_pkg::swap_byte_bits(data1) : data1;
        o_res.res1.write_mask     = r_msb_first ? bfca_pkg::swap_byte_bits(mask1) : mask1;
        o_res.res1.last_out       = 1'b1;
    end

    // state update
    always_comb begin
        n_pend      = r_pend;
        n_pcnt      = r_pcnt;
        n_bits_left = r_bits_left;
        n_first     = r_first;
        n_fresh     = r_fresh;
        if (i_adv) begin
            n_first = 1'b0;
            if (!active) begin
                n_bits_left = '0;
            end else if (!emit0) begin
                n_pend      = p[HW-1:0];
                n_pcnt      = cur[3:0];
                n_bits_left = bl;
            end else if (last0 || emit1) begin
                n_pend      = '0;
                n_pcnt      = '0;
                n_bits_left = '0;
                n_fresh     = 1'b0;
            end else begin
                n_pend      = p1;
                n_pcnt      = c1[3:0];
                n_bits_left = bl1;
                n_fresh     = 1'b0;
            end
        end
        if (cfg_hit) begin
            n_pend      = '0;
            n_pcnt      = '0;
            n_bits_left = '0;
            n_first     = 1'b1;
            n_fresh     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_pcnt      <= '0;
            r_bits_left <= '0;
            r_first     <= 1'b1;
            r_fresh     <= 1'b1;
        end else begin
            r_pend      <= n_pend;
            r_pcnt      <= n_pcnt;
            r_bits_left <= n_bits_left;
            r_first     <= n_first;
            r_fresh     <= n_fresh;
        end
    end

endmodule

// File: rtl/bfca_out_stage.sv
// two-slot result register driving the destination stream
// depends on bfca_pkg and bfca_dst_if
module bfca_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bfca_pkg::t_res_pair i_res,
    output logic                o_can_load,
    bfca_dst_if.source          o_dst
);

    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;
    bfca_pkg::t_dst_item r_slot0;
    bfca_pkg::t_dst_item n_slot0;
    bfca_pkg::t_dst_item r_slot1;
    bfca_pkg::t_dst_item n_slot1;
    logic                pop;

    assign pop        = (r_cnt != 2'd0) && o_dst.ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_dst.ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_load) begin
            n_cnt   = i_res.emit1 ? 2'd2 : {1'b0, i_res.emit0};
            n_slot0 = i_res.res0;
            n_slot1 = i_res.res1;
        end else if (pop) begin
            n_cnt   = r_cnt - 2'd1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_dst.valid      = (r_cnt != 2'd0);
    assign o_dst.dst_half   = r_slot0.dst_half;
    assign o_dst.write_mask = r_slot0.write_mask;
    assign o_dst.last_out   = r_slot0.last_out;

endmodule

// File: rtl/bfca_checker.sv
// port-level assertions for the bit field copy aligner, bound to the top level
// depends on bit_field_copy_aligner_assert.svh and bit_field_copy_aligner
`include "bit_field_copy_aligner_assert.svh"

module bfca_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_src_valid,
    input logic i_src_ready,
    input logic i_dst_valid,
    input logic i_dst_ready
);

    // a waiting result stays offered
    `BFCA_ASSERT(a_dst_hold, i_clk, i_rst_n, (i_dst_valid && !i_dst_ready) |=> i_dst_valid, "destination transaction dropped before it was taken")

    // reset empties both stages
    `BFCA_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> (!i_dst_valid && i_src_ready), "block not empty after reset")

    // with no result waiting the block always takes a source transaction
    `BFCA_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_dst_valid |-> i_src_ready, "source stalled with empty result register")

    // a result appears only after a source transaction has been taken
    `BFCA_ASSERT(a_result_latency, i_clk, i_rst_n, $rose(i_dst_valid) |-> $past(i_src_valid && i_src_ready, 2), "result without a source transaction two cycles earlier")

endmodule

bind bit_field_copy_aligner bfca_checker u_bfca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_src_valid (i_src.valid),
    .i_src_ready (i_src.ready),
    .i_dst_valid (o_dst.valid),
    .i_dst_ready (o_dst.ready)
);
